>>> hw/rtl/hgfe_pkg.sv
// hgfe_pkg: shared types, constants and recurrence coefficient tables
// for the oscillator wavefunction evaluator; no dependencies
package hgfe_pkg;

    localparam int WFRAC      = 56;
    localparam int CFRAC      = 31;
    localparam int TAY_TERMS  = 20;
    localparam int SRCH_K_MAX = 63;
    localparam int EXP_K_MAX  = 60;
    localparam int TAB_MAX    = 12;
    localparam int TAB_DEPTH  = 16;

    localparam logic [63:0] LN2_Q56   = 64'h00B17217F7D1CF7A;
    localparam logic [63:0] PI_M4_Q32 = 64'd3226059649;
    localparam logic signed [63:0] VAL_MAX = 64'sd131071;
    localparam logic signed [63:0] VAL_MIN = -64'sd131072;

    typedef enum logic [2:0] {
        MS_TAY = 3'd0,
        MS_PI  = 3'd1,
        MS_AX  = 3'd2,
        MS_T1  = 3'd3,
        MS_T2  = 3'd4
    } mul_sel_t;

    typedef struct packed {
        logic       load;
        logic       srch_step;
        logic       tay_init;
        logic       mul_start;
        mul_sel_t   mul_sel;
        logic       div_start;
        logic       exp_fin;
        logic       out_wr;
        logic [4:0] idx;
    } cmd_t;

    typedef struct packed {
        logic       srch_done;
        logic       mul_done;
        logic       div_done;
        logic       special;
        logic       exp_zero;
        logic       out_free;
        logic [3:0] order;
    } status_t;

    typedef logic [63:0] coef_tab_t [TAB_DEPTH];

    function automatic logic [63:0] isqrt_f(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] r;
        logic [63:0] bitv;
        v    = v_in;
        r    = 64'd0;
        bitv = 64'd1 << 62;
        for (int j = 0; j < 32; j++)
        begin
            if (v >= r + bitv)
            begin
                v = v - (r + bitv);
                r = (r >> 1) + bitv;
            end
            else
            begin
                r = r >> 1;
            end
            bitv = bitv >> 2;
        end
        return r;
    endfunction

    function automatic logic [63:0] udiv_f(input logic [63:0] n, input logic [63:0] d);
        logic [63:0] rem;
        logic [63:0] q;
        rem = 64'd0;
        q   = 64'd0;
        for (int j = 63; j >= 0; j--)
        begin
            rem = {rem[62:0], n[j]};
            if (rem >= d)
            begin
                rem  = rem - d;
                q[j] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic coef_tab_t coef_a_f();
        coef_tab_t t;
        for (int k = 0; k < TAB_DEPTH; k++)
        begin
            if (k >= 1 && k <= TAB_MAX)
                t[k] = isqrt_f(udiv_f(64'd1 << 63, 64'(k)));
            else
                t[k] = 64'd0;
        end
        return t;
    endfunction

    function automatic coef_tab_t coef_b_f();
        coef_tab_t t;
        for (int k = 0; k < TAB_DEPTH; k++)
        begin
            if (k >= 1 && k <= TAB_MAX)
                t[k] = isqrt_f((64'd1 << 62) - udiv_f(64'd1 << 62, 64'(k)));
            else
                t[k] = 64'd0;
        end
        return t;
    endfunction

    localparam coef_tab_t COEF_A = coef_a_f();
    localparam coef_tab_t COEF_B = coef_b_f();

endpackage

>>> hw/rtl/hgfe_if.sv
// hgfe_in_if / hgfe_out_if: valid/ready channels for input and result words
// no dependencies
interface hgfe_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         mode;
    logic [3:0]         order;
    logic signed [15:0] arg;

    modport source (output valid, output mode, output order, output arg, input ready);
    modport sink   (input valid, input mode, input order, input arg, output ready);
endinterface

interface hgfe_out_if;
    logic               valid;
    logic               ready;
    logic signed [17:0] value;
    logic               bad_order;

    modport source (output valid, output value, output bad_order, input ready);
    modport sink   (input valid, input value, input bad_order, output ready);
endinterface

>>> hw/rtl/hgfe_mul.sv
// hgfe_mul: shared signed 64x64 multiplier, four 32x32 partial products,
// then round-to-nearest right shift; no package dependency
module hgfe_mul (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [63:0] a,
    input  logic signed [63:0] b,
    input  logic [5:0]         sh,
    output logic               done,
    output logic signed [63:0] res
);
    logic [63:0]  ua_reg, ub_reg;
    logic         neg_reg;
    logic [5:0]   sh_reg;
    logic [127:0] prod_reg;
    logic [2:0]   cnt_reg;
    logic         busy_reg;
    logic         done_reg;
    logic [63:0]  res_reg;

    logic [31:0]  a_part, b_part;
    logic [63:0]  pp;
    logic [127:0] pp_sh;
    logic [127:0] rnd_sum;
    logic [63:0]  r;

    always_comb
    begin
        a_part = cnt_reg[0] ? ua_reg[63:32] : ua_reg[31:0];
        b_part = cnt_reg[1] ? ub_reg[63:32] : ub_reg[31:0];
        pp     = a_part * b_part;
        case (cnt_reg[1:0])
            2'd0:    pp_sh = {64'd0, pp};
            2'd3:    pp_sh = {pp, 64'd0};
            default: pp_sh = {32'd0, pp, 32'd0};
        endcase
        rnd_sum = prod_reg + ((128'd1 << sh_reg) >> 1);
        r       = 64'(rnd_sum >> sh_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 3'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 3'd0;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == 3'd4)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                cnt_reg <= cnt_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            ua_reg   <= a[63] ? 64'(-a) : 64'(a);
            ub_reg   <= b[63] ? 64'(-b) : 64'(b);
            neg_reg  <= a[63] ^ b[63];
            sh_reg   <= sh;
            prod_reg <= 128'd0;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == 3'd4)
                res_reg <= neg_reg ? 64'(-r) : r;
            else
                prod_reg <= prod_reg + pp_sh;
        end
    end

    assign done = done_reg;
    assign res  = res_reg;

endmodule

>>> hw/rtl/hgfe_dp.sv
// hgfe_dp: datapath registers, exponent search, series divider,
// recurrence and output word register; uses hgfe_pkg and hgfe_mul
module hgfe_dp #(
    parameter int MAX_ORDER     = 12,
    parameter int ARG_FRAC_BITS = 11,
    parameter int OUT_FRAC_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  hgfe_pkg::cmd_t      cmd,
    output hgfe_pkg::status_t   sts,
    input  logic [1:0]          in_mode,
    input  logic [3:0]          in_order,
    input  logic signed [15:0]  in_arg,
    output logic                out_valid,
    input  logic                out_ready,
    output logic signed [17:0]  out_value,
    output logic                out_bad
);
    import hgfe_pkg::*;

    localparam int SQ_SH  = 2 * ARG_FRAC_BITS + 1;
    localparam int T_SH   = WFRAC - SQ_SH;
    localparam int T1_SH  = CFRAC + ARG_FRAC_BITS;
    localparam int OUT_SH = WFRAC - OUT_FRAC_BITS;
    localparam logic [63:0] T_LIM  = 64'd64 << SQ_SH;
    localparam logic signed [63:0] ONE_OUT = 64'sd1 <<< OUT_FRAC_BITS;
    localparam logic signed [63:0] ONE_W   = 64'sd1 <<< WFRAC;

    logic [1:0]         mode_reg;
    logic [3:0]         order_reg;
    logic signed [15:0] arg_reg;
    logic [31:0]        traw_reg;
    logic [5:0]         k_reg;
    logic [63:0]        acc_reg;
    logic signed [63:0] sum_reg, term_reg, g_reg, expv_reg;
    logic signed [63:0] p_reg, prev_reg, ax_reg, t1_reg;
    mul_sel_t           sel_reg;

    logic [63:0]        dq_reg;
    logic [4:0]         rem_reg;
    logic [4:0]         dvs_reg;
    logic [5:0]         dcnt_reg;
    logic               dbusy_reg, dneg_reg, ddone_reg;

    logic               out_valid_reg, out_bad_reg;
    logic signed [17:0] out_value_reg;

    logic [63:0]        t_val, acc_nx;
    logic               step_ok;
    logic               bad;
    logic signed [63:0] mul_a, mul_b, mul_res;
    logic [5:0]         mul_sh;
    logic               mul_done;
    logic [5:0]         trial;
    logic               qbit;
    logic [63:0]        quot;
    logic signed [63:0] nterm;
    logic [63:0]        exp_rnd;
    logic signed [63:0] v_rnd, v_fin;

    function automatic logic signed [17:0] sat_f(input logic signed [63:0] v);
        if (v > VAL_MAX)
            return 18'(VAL_MAX);
        if (v < VAL_MIN)
            return 18'(VAL_MIN);
        return 18'(v);
    endfunction

    always_comb
    begin
        t_val   = 64'(traw_reg) << T_SH;
        acc_nx  = acc_reg + LN2_Q56;
        step_ok = (k_reg < 6'(SRCH_K_MAX)) && (acc_nx <= t_val);
        bad     = 32'(order_reg) > 32'(MAX_ORDER);

        mul_a  = term_reg;
        mul_b  = g_reg;
        mul_sh = 6'(WFRAC);
        case (cmd.mul_sel)
            MS_TAY:
            begin
                mul_a  = term_reg;
                mul_b  = g_reg;
                mul_sh = 6'(WFRAC);
            end
            MS_PI:
            begin
                mul_a  = $signed(PI_M4_Q32);
                mul_b  = expv_reg;
                mul_sh = 6'd32;
            end
            MS_AX:
            begin
                mul_a  = $signed(COEF_A[cmd.idx[3:0]]);
                mul_b  = 64'(arg_reg);
                mul_sh = 6'd0;
            end
            MS_T1:
            begin
                mul_a  = ax_reg;
                mul_b  = p_reg;
                mul_sh = 6'(T1_SH);
            end
            MS_T2:
            begin
                mul_a  = $signed(COEF_B[cmd.idx[3:0]]);
                mul_b  = prev_reg;
                mul_sh = 6'(CFRAC);
            end
            default:
            begin
                mul_a  = term_reg;
                mul_b  = g_reg;
                mul_sh = 6'(WFRAC);
            end
        endcase

        trial = {rem_reg, dq_reg[63]};
        qbit  = trial >= 6'(dvs_reg);
        quot  = {dq_reg[62:0], qbit};
        nterm = dneg_reg ? $signed(64'(-quot)) : $signed(quot);

        exp_rnd = 64'(sum_reg) + ((64'd1 << k_reg) >> 1);

        v_rnd = $signed(p_reg + (64'sd1 <<< (OUT_SH - 1))) >>> OUT_SH;
        v_fin = (mode_reg == 2'd1) ? v_rnd + ONE_OUT : v_rnd;
    end

    hgfe_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .sh    (mul_sh),
        .done  (mul_done),
        .res   (mul_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dbusy_reg     <= 1'b0;
            ddone_reg     <= 1'b0;
            dcnt_reg      <= 6'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            ddone_reg <= 1'b0;
            if (cmd.div_start)
            begin
                dbusy_reg <= 1'b1;
                dcnt_reg  <= 6'd0;
            end
            else if (dbusy_reg)
            begin
                dcnt_reg <= dcnt_reg + 6'd1;
                if (dcnt_reg == 6'd63)
                begin
                    dbusy_reg <= 1'b0;
                    ddone_reg <= 1'b1;
                end
            end
            if (cmd.out_wr)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg  <= in_mode;
            order_reg <= in_order;
            arg_reg   <= in_arg;
            traw_reg  <= 32'($unsigned(32'(in_arg * in_arg)));
            k_reg     <= 6'd0;
            acc_reg   <= 64'd0;
        end
        if (cmd.srch_step && step_ok)
        begin
            k_reg   <= k_reg + 6'd1;
            acc_reg <= acc_nx;
        end
        if (cmd.tay_init)
        begin
            sum_reg  <= ONE_W;
            term_reg <= ONE_W;
            g_reg    <= $signed(t_val - acc_reg);
        end
        if (cmd.mul_start)
            sel_reg <= cmd.mul_sel;
        if (mul_done)
        begin
            case (sel_reg)
                MS_PI:
                begin
                    p_reg    <= mul_res;
                    prev_reg <= 64'sd0;
                end
                MS_AX:   ax_reg <= mul_res;
                MS_T1:   t1_reg <= mul_res;
                MS_T2:
                begin
                    prev_reg <= p_reg;
                    p_reg    <= t1_reg - mul_res;
                end
                default: ;
            endcase
        end
        if (cmd.div_start)
        begin
            dq_reg   <= mul_res[63] ? 64'(-mul_res) : 64'(mul_res);
            dneg_reg <= mul_res[63];
            rem_reg  <= 5'd0;
            dvs_reg  <= cmd.idx;
        end
        else if (dbusy_reg)
        begin
            dq_reg  <= quot;
            rem_reg <= qbit ? 5'(trial - 6'(dvs_reg)) : trial[4:0];
            if (dcnt_reg == 6'd63)
            begin
                term_reg <= nterm;
                sum_reg  <= dvs_reg[0] ? sum_reg - nterm : sum_reg + nterm;
            end
        end
        if (cmd.exp_fin)
        begin
            if (sts.exp_zero)
                expv_reg <= 64'sd0;
            else if (k_reg == 6'd0)
                expv_reg <= sum_reg;
            else
                expv_reg <= $signed(exp_rnd) >>> k_reg;
        end
        if (cmd.out_wr)
        begin
            if (mode_reg[1])
            begin
                out_value_reg <= sat_f(ONE_OUT);
                out_bad_reg   <= 1'b0;
            end
            else if (bad)
            begin
                out_value_reg <= 18'sd0;
                out_bad_reg   <= 1'b1;
            end
            else
            begin
                out_value_reg <= sat_f(v_fin);
                out_bad_reg   <= 1'b0;
            end
        end
    end

    always_comb
    begin
        sts.srch_done = !step_ok;
        sts.mul_done  = mul_done;
        sts.div_done  = ddone_reg;
        sts.special   = mode_reg[1] || bad;
        sts.exp_zero  = (64'(traw_reg) >= T_LIM) || (k_reg >= 6'(EXP_K_MAX));
        sts.out_free  = !out_valid_reg || out_ready;
        sts.order     = order_reg;
    end

    assign out_valid = out_valid_reg;
    assign out_value = out_value_reg;
    assign out_bad   = out_bad_reg;

endmodule

>>> hw/rtl/hgfe_ctrl.sv
// hgfe_ctrl: sequencer for search, series, scaling and recurrence steps
// uses hgfe_pkg command and status types
module hgfe_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  hgfe_pkg::status_t sts,
    output hgfe_pkg::cmd_t    cmd
);
    import hgfe_pkg::*;

    typedef enum logic [16:0] {
        S_IDLE  = 17'h00001,
        S_CHK   = 17'h00002,
        S_SRCH  = 17'h00004,
        S_TINIT = 17'h00008,
        S_TMUL  = 17'h00010,
        S_TMW   = 17'h00020,
        S_TDIV  = 17'h00040,
        S_EXPF  = 17'h00080,
        S_PIM   = 17'h00100,
        S_PIW   = 17'h00200,
        S_AXM   = 17'h00400,
        S_AXW   = 17'h00800,
        S_T1M   = 17'h01000,
        S_T1W   = 17'h02000,
        S_T2M   = 17'h04000,
        S_T2W   = 17'h08000,
        S_OUT   = 17'h10000
    } state_t;

    state_t     state_reg, state_next;
    logic [4:0] idx_reg, idx_next;

    always_comb
    begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        cmd           = '0;
        cmd.mul_sel   = MS_TAY;
        cmd.idx       = idx_reg;
        in_ready      = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CHK;
                end
            end
            S_CHK:   state_next = sts.special ? S_OUT : S_SRCH;
            S_SRCH:
            begin
                if (sts.srch_done)
                    state_next = S_TINIT;
                else
                    cmd.srch_step = 1'b1;
            end
            S_TINIT:
            begin
                cmd.tay_init = 1'b1;
                idx_next     = 5'd1;
                state_next   = sts.exp_zero ? S_EXPF : S_TMUL;
            end
            S_TMUL:
            begin
                cmd.mul_start = 1'b1;
                cmd.mul_sel   = MS_TAY;
                state_next    = S_TMW;
            end
            S_TMW:
            begin
                if (sts.mul_done)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_TDIV;
                end
            end
            S_TDIV:
            begin
                if (sts.div_done)
                begin
                    if (idx_reg == 5'(TAY_TERMS))
                        state_next = S_EXPF;
                    else
                    begin
                        idx_next   = idx_reg + 5'd1;
                        state_next = S_TMUL;
                    end
                end
            end
            S_EXPF:
            begin
                cmd.exp_fin = 1'b1;
                state_next  = S_PIM;
            end
            S_PIM:
            begin
                cmd.mul_start = 1'b1;
                cmd.mul_sel   = MS_PI;
                state_next    = S_PIW;
            end
            S_PIW:
            begin
                if (sts.mul_done)
                begin
                    idx_next   = 5'd1;
                    state_next = (sts.order == 4'd0) ? S_OUT : S_AXM;
                end
            end
            S_AXM:
            begin
                cmd.mul_start = 1'b1;
                cmd.mul_sel   = MS_AX;
                state_next    = S_AXW;
            end
            S_AXW:   if (sts.mul_done) state_next = S_T1M;
            S_T1M:
            begin
                cmd.mul_start = 1'b1;
                cmd.mul_sel   = MS_T1;
                state_next    = S_T1W;
            end
            S_T1W:   if (sts.mul_done) state_next = S_T2M;
            S_T2M:
            begin
                cmd.mul_start = 1'b1;
                cmd.mul_sel   = MS_T2;
                state_next    = S_T2W;
            end
            S_T2W:
            begin
                if (sts.mul_done)
                begin
                    if (idx_reg == {1'b0, sts.order})
                        state_next = S_OUT;
                    else
                    begin
                        idx_next   = idx_reg + 5'd1;
                        state_next = S_AXM;
                    end
                end
            end
            S_OUT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_wr = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= 5'd0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

endmodule

>>> hw/rtl/hermite_gauss_function_eval.sv
// hermite_gauss_function_eval: normalized Hermite function evaluator, top level
// uses hgfe_pkg, hgfe_if, hgfe_ctrl, hgfe_dp
//
// in_ch carries one word (mode, order, arg); out_ch returns one word
// (value, bad_order) per input word, in order.
// one word is worked on at a time; in_ch.ready is high only while idle.
// constant mode and bad orders go straight to the output; otherwise
// an exponent range search, then 20 series terms (shared multiplier
// plus a bit-serial divider, which dominates), then three multiplies
// per Hermite order; the series is skipped in the far tails.
// the result sits in an output register; a new input word is taken
// while it waits, and if the receiver stalls the next result waits in
// the datapath until the register frees up.
// reset clears the sequencer and the output valid; no init pass
module hermite_gauss_function_eval #(
    parameter int MAX_ORDER     = 12,
    parameter int ARG_FRAC_BITS = 11,
    parameter int OUT_FRAC_BITS = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    hgfe_in_if.sink    in_ch,
    hgfe_out_if.source out_ch
);
    import hgfe_pkg::*;

    cmd_t    cmd;
    status_t sts;

    hgfe_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    hgfe_dp #(
        .MAX_ORDER     (MAX_ORDER),
        .ARG_FRAC_BITS (ARG_FRAC_BITS),
        .OUT_FRAC_BITS (OUT_FRAC_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .in_mode   (in_ch.mode),
        .in_order  (in_ch.order),
        .in_arg    (in_ch.arg),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .out_value (out_ch.value),
        .out_bad   (out_ch.bad_order)
    );

    // one word in flight
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
        else $error("input taken while busy");

    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.bad_order) |-> (out_ch.value == 18'sd0))
        else $error("bad order with nonzero value");

    a_no_dual_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mul_start |-> !cmd.div_start && !cmd.out_wr)
        else $error("conflicting datapath commands");

endmodule
